// ===== src/flv_tag_h264_nal_extractor_assert.svh =====
// ----------------------------------------------------------------------------
// FLV H.264 NAL extractor assertion macros
// Shared concurrent assertion forms for the extractor's internal checks.
// ----------------------------------------------------------------------------
`ifndef FLV_TAG_H264_NAL_EXTRACTOR_ASSERT_SVH
`define FLV_TAG_H264_NAL_EXTRACTOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FLVN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("flvn assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FLVN_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("flvn assertion failed");

`endif

// ===== src/flvn_pkg.sv =====
// ----------------------------------------------------------------------------
// FLV H.264 NAL extractor package
// Stream constants and the result record passed from parser to top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flvn_pkg;

  localparam logic [7:0] SIG_F       = 8'h46;
  localparam logic [7:0] SIG_L       = 8'h4c;
  localparam logic [7:0] SIG_V       = 8'h56;
  localparam logic [7:0] TAG_VIDEO   = 8'h09;
  localparam logic [3:0] CODEC_AVC   = 4'h7;
  localparam logic [7:0] AVC_NALU    = 8'h01;
  localparam logic [31:0] HDR_LEN    = 32'd9;

  typedef struct packed {
    logic        emit;
    logic [7:0]  nal_byte;
    logic        nal_first;
    logic        nal_last;
    logic [31:0] timestamp_ms;
    logic [23:0] composition_offset;
    logic [3:0]  frame_kind;
    logic        truncated;
  } flvn_result_t;

endpackage

// ===== src/flvn_parser.sv =====
// ----------------------------------------------------------------------------
// FLV tag parser
// Walks header and tags one byte per step and produces NAL payload results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flvn_parser (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  logic [7:0]           byte_i,
  output flvn_pkg::flvn_result_t res_o
);
  import flvn_pkg::*;

  typedef enum logic [3:0] {
    PH_SIG, PH_VERFLAGS, PH_OFFSET, PH_HSKIP, PH_PREV, PH_TYPE, PH_SIZE, PH_TS,
    PH_SID, PH_CODEC, PH_PKT, PH_CTS, PH_NLEN, PH_NDATA, PH_BSKIP
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  sig_q, sig_d;
  logic [2:0]  cnt_q, cnt_d;
  logic [31:0] shift_q, shift_d;
  logic [31:0] skip_q, skip_d;
  logic [7:0]  kind_q, kind_d;
  logic [23:0] tag_left_q, tag_left_d;
  logic [31:0] nal_left_q, nal_left_d;
  logic [31:0] ts_q, ts_d;
  logic [23:0] cts_q, cts_d;
  logic [3:0]  fk_q, fk_d;
  logic        started_q, started_d;

  logic [2:0]  cnt_inc;
  logic [31:0] shift_in;
  logic [31:0] skip_dec;
  logic [23:0] tag_dec;
  logic [31:0] nal_dec;

  assign cnt_inc  = cnt_q + 3'd1;
  assign shift_in = {shift_q[23:0], byte_i};
  assign skip_dec = skip_q - {31'd0, (skip_q != 32'd0)};
  assign tag_dec  = tag_left_q - 24'd1;
  assign nal_dec  = nal_left_q - {31'd0, (nal_left_q != 32'd0)};

  always_comb begin
    phase_d    = phase_q;
    sig_d      = sig_q;
    cnt_d      = cnt_q;
    shift_d    = shift_q;
    skip_d     = skip_q;
    kind_d     = kind_q;
    tag_left_d = tag_left_q;
    nal_left_d = nal_left_q;
    ts_d       = ts_q;
    cts_d      = cts_q;
    fk_d       = fk_q;
    started_d  = started_q;
    res_o      = '0;
    res_o.nal_byte           = byte_i;
    res_o.nal_first          = ~started_q;
    res_o.timestamp_ms       = ts_q;
    res_o.composition_offset = cts_q;
    res_o.frame_kind         = fk_q;
    res_o.truncated          = (nal_left_q > {8'd0, tag_left_q});
    res_o.nal_last           = (nal_dec == 32'd0) || (tag_dec == 24'd0);

    case (phase_q)
      PH_SIG: begin
        if (sig_q == 2'd1 && byte_i == SIG_L) begin
          sig_d = 2'd2;
        end else if (sig_q == 2'd2 && byte_i == SIG_V) begin
          sig_d   = 2'd0;
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_VERFLAGS;
        end else begin
          sig_d = (byte_i == SIG_F) ? 2'd1 : 2'd0;
        end
      end
      PH_VERFLAGS: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= 3'd2) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_OFFSET;
        end
      end
      PH_OFFSET: begin
        cnt_d   = cnt_inc;
        shift_d = shift_in;
        if (cnt_inc >= 3'd4) begin
          cnt_d   = '0;
          shift_d = '0;
          if (shift_in > HDR_LEN) begin
            skip_d  = shift_in - HDR_LEN;
            phase_d = PH_HSKIP;
          end else begin
            skip_d  = '0;
            phase_d = PH_PREV;
          end
        end
      end
      PH_HSKIP: begin
        skip_d = skip_dec;
        if (skip_dec == 32'd0) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_PREV;
        end
      end
      PH_PREV: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= 3'd4) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_TYPE;
        end
      end
      PH_TYPE: begin
        kind_d  = byte_i;
        cnt_d   = '0;
        shift_d = '0;
        phase_d = PH_SIZE;
      end
      PH_SIZE: begin
        cnt_d   = cnt_inc;
        shift_d = shift_in;
        if (cnt_inc >= 3'd3) begin
          tag_left_d = shift_in[23:0];
          cnt_d      = '0;
          shift_d    = '0;
          phase_d    = PH_TS;
        end
      end
      PH_TS: begin
        if (cnt_q < 3'd3) begin
          cnt_d   = cnt_inc;
          shift_d = shift_in;
        end else begin
          ts_d    = {byte_i, shift_q[23:0]};
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_SID;
        end
      end
      PH_SID: begin
        cnt_d = cnt_inc;
        if (cnt_inc >= 3'd3) begin
          cnt_d     = '0;
          shift_d   = '0;
          started_d = 1'b0;
          if (tag_left_q == 24'd0) begin
            phase_d = PH_PREV;
          end else if (kind_q == TAG_VIDEO) begin
            phase_d = PH_CODEC;
          end else begin
            phase_d = PH_BSKIP;
          end
        end
      end
      PH_CODEC, PH_PKT, PH_CTS, PH_NLEN, PH_NDATA, PH_BSKIP: begin
        if (tag_left_q == 24'd0) begin
          cnt_d   = '0;
          shift_d = '0;
          phase_d = PH_PREV;
        end else begin
          tag_left_d = tag_dec;
          case (phase_q)
            PH_CODEC: begin
              fk_d    = byte_i[7:4];
              phase_d = (byte_i[3:0] == CODEC_AVC) ? PH_PKT : PH_BSKIP;
              cnt_d   = '0;
              shift_d = '0;
            end
            PH_PKT: begin
              phase_d = (byte_i == AVC_NALU) ? PH_CTS : PH_BSKIP;
              cnt_d   = '0;
              shift_d = '0;
            end
            PH_CTS: begin
              cnt_d   = cnt_inc;
              shift_d = shift_in;
              if (cnt_inc >= 3'd3) begin
                cts_d   = shift_in[23:0];
                cnt_d   = '0;
                shift_d = '0;
                phase_d = PH_NLEN;
              end
            end
            PH_NLEN: begin
              cnt_d   = cnt_inc;
              shift_d = shift_in;
              if (cnt_inc >= 3'd4) begin
                nal_left_d = shift_in;
                cnt_d      = '0;
                shift_d    = '0;
                started_d  = 1'b0;
                phase_d    = (shift_in != 32'd0) ? PH_NDATA : PH_NLEN;
              end
            end
            PH_NDATA: begin
              res_o.emit = 1'b1;
              started_d  = 1'b1;
              nal_left_d = nal_dec;
              if (nal_dec == 32'd0) begin
                started_d = 1'b0;
                cnt_d     = '0;
                shift_d   = '0;
                phase_d   = PH_NLEN;
              end
            end
            default: begin
            end
          endcase
          // Tag end overrides whatever the body phase chose.
          if (tag_dec == 24'd0) begin
            cnt_d     = '0;
            shift_d   = '0;
            started_d = 1'b0;
            phase_d   = PH_PREV;
          end
        end
      end
      default: begin
        phase_d    = PH_SIG;
        sig_d      = '0;
        cnt_d      = '0;
        shift_d    = '0;
        skip_d     = '0;
        kind_d     = '0;
        tag_left_d = '0;
        nal_left_d = '0;
        ts_d       = '0;
        cts_d      = '0;
        fk_d       = '0;
        started_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_SIG;
      sig_q      <= '0;
      cnt_q      <= '0;
      shift_q    <= '0;
      skip_q     <= '0;
      kind_q     <= '0;
      tag_left_q <= '0;
      nal_left_q <= '0;
      ts_q       <= '0;
      cts_q      <= '0;
      fk_q       <= '0;
      started_q  <= 1'b0;
    end else if (step_i) begin
      phase_q    <= phase_d;
      sig_q      <= sig_d;
      cnt_q      <= cnt_d;
      shift_q    <= shift_d;
      skip_q     <= skip_d;
      kind_q     <= kind_d;
      tag_left_q <= tag_left_d;
      nal_left_q <= nal_left_d;
      ts_q       <= ts_d;
      cts_q      <= cts_d;
      fk_q       <= fk_d;
      started_q  <= started_d;
    end
  end

endmodule

// ===== src/flv_tag_h264_nal_extractor.sv =====
// ----------------------------------------------------------------------------
// FLV tag H.264 NAL extractor
// Pulls length-prefixed H.264 NAL unit bytes out of an FLV byte stream.
// ----------------------------------------------------------------------------
// Feed the FLV stream one byte per request on the data channel; each NAL
// payload byte comes out as one request on the nal channel, tagged with
// first/last flags, the tag timestamp, the AVC composition offset, the frame
// type nibble and a truncated flag for units that ran past their tag. Each
// byte is captured in an input register, parsed by the header/tag state
// machine in a single pass, and any result lands in the output register
// when the parser steps on that byte, and is offered on the nal channel
// from there. Throughput is one byte per cycle while the output register is
// free or being taken; a byte that produces no result is held to the same
// condition. The input side keeps accepting while a result waits, as long as
// the output register is free or being taken in the same cycle.
`timescale 1ns / 1ps

module flv_tag_h264_nal_extractor (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        data_valid_i,
  output logic        data_ready_o,
  input  logic [7:0]  data_byte_i,
  output logic        nal_valid_o,
  input  logic        nal_ready_i,
  output logic [7:0]  nal_byte_o,
  output logic        nal_first_o,
  output logic        nal_last_o,
  output logic [31:0] timestamp_ms_o,
  output logic [23:0] composition_offset_o,
  output logic [3:0]  frame_kind_o,
  output logic        truncated_o
);
  import flvn_pkg::*;

  `include "flv_tag_h264_nal_extractor_assert.svh"

  // Input stage: holds one accepted byte until the parser steps on it.
  logic         in_valid_q;
  logic [7:0]   in_byte_q;
  // Output stage: one finished result waiting for the consumer.
  logic         out_valid_q;
  flvn_result_t out_q;
  flvn_result_t res;
  logic         advance;

  // Step the parser whenever a byte is held and the output slot is free
  // or being drained this cycle.
  assign advance      = in_valid_q && (!out_valid_q || nal_ready_i);
  assign data_ready_o = !in_valid_q || advance;

  flvn_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (advance),
    .byte_i (in_byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (data_ready_o) begin
        in_valid_q <= data_valid_i;
      end
      if (advance) begin
        out_valid_q <= res.emit;
      end else if (nal_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers: capture only, no reset needed.
  always_ff @(posedge clk_i) begin
    if (data_ready_o && data_valid_i) begin
      in_byte_q <= data_byte_i;
    end
    if (advance && res.emit) begin
      out_q <= res;
    end
  end

  assign nal_valid_o          = out_valid_q;
  assign nal_byte_o           = out_q.nal_byte;
  assign nal_first_o          = out_q.nal_first;
  assign nal_last_o           = out_q.nal_last;
  assign timestamp_ms_o       = out_q.timestamp_ms;
  assign composition_offset_o = out_q.composition_offset;
  assign frame_kind_o         = out_q.frame_kind;
  assign truncated_o          = out_q.truncated;

  // A held byte that cannot step must stay put.
  `FLVN_ASSERT_NXT(a_in_hold, clk_i, rst_ni, in_valid_q && !advance, in_valid_q && $stable(in_byte_q))
  // An emitted result must show up in the output register next cycle.
  `FLVN_ASSERT_NXT(a_emit_lands, clk_i, rst_ni, advance && res.emit, out_valid_q)
  // Never step the parser over a result that is still waiting.
  `FLVN_ASSERT_IMP(a_no_overwrite, clk_i, rst_ni, advance && out_valid_q, nal_ready_i)

endmodule
